// ===== design/bhp_pkg.sv =====
// Shared constants, types and helpers of the bucket histogram with percentile estimates.
package bhp_pkg;

  localparam int MAX_BOUNDS  = 8;
  localparam int COUNT_WIDTH = 48;
  localparam int VALUE_WIDTH = 32;

  localparam int NUM_BUCKETS = MAX_BOUNDS + 1;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int NUM_PAIRS   = 4;
  localparam int PAIR_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int SUM_W       = 64;
  // Cumulative bucket sum and its value scaled by one hundred.
  localparam int CUM_W       = COUNT_WIDTH + IDX_W;
  localparam int SCALE_W     = CUM_W + 7;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] bound_regs_t;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUNDS_IN_USE = 3'd0,
    REG_PAIR_A        = 3'd1,
    REG_PAIR_B        = 3'd2,
    REG_PAIR_C        = 3'd3,
    REG_PAIR_D        = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  bucket_index;
    logic [47:0] bucket_count;
    logic [47:0] total_count;
    logic [63:0] value_sum;
    logic [31:0] median_estimate;
    logic [31:0] p95_estimate;
    logic [31:0] p99_estimate;
    logic        last_bucket;
  } out_item_t;

  // Control from the query sequencer to the percentile scan unit.
  typedef struct packed {
    logic start;
    logic step;
    idx_t idx;
  } scan_ctrl_t;

  // Bound i sits in pair i/2, low half for even i and high half for odd i.
  function automatic value_t bound_at(input bound_regs_t regs, input idx_t i);
    logic [PAIR_W-1:0] pair;
    pair = regs[2'(i >> 1)];
    return i[0] ? value_t'(pair[63:32]) : value_t'(pair[31:0]);
  endfunction

  function automatic idx_t active_bounds(input logic [3:0] b);
    if (32'(b) > MAX_BOUNDS) begin
      return idx_t'(MAX_BOUNDS);
    end
    return idx_t'(b);
  endfunction

endpackage

// ===== design/bhp_pct_scan.sv =====
// Percentile scan unit: accumulates bucket counts in order and picks p50, p95 and p99 bounds.
module bhp_pct_scan
  import bhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  scan_ctrl_t  ctrl,
  input  count_t      count,
  input  count_t      total,
  input  idx_t        n,
  input  bound_regs_t bounds,
  output value_t      p50,
  output value_t      p95,
  output value_t      p99
);

  // Constant multiplications written as shift-add trees.
  function automatic logic [SCALE_W-1:0] times50(input logic [SCALE_W-1:0] y);
    return (y << 5) + (y << 4) + (y << 1);
  endfunction

  function automatic logic [SCALE_W-1:0] times95(input logic [SCALE_W-1:0] y);
    return (y << 6) + (y << 5) - y;
  endfunction

  function automatic logic [SCALE_W-1:0] times99(input logic [SCALE_W-1:0] y);
    return (y << 6) + (y << 5) + (y << 1) + y;
  endfunction

  function automatic logic [SCALE_W-1:0] times100(input logic [SCALE_W-1:0] y);
    return (y << 6) + (y << 5) + (y << 2);
  endfunction

  logic [SCALE_W-1:0]          cum_r;
  logic [2:0][SCALE_W-1:0]     tgt_r;
  logic [2:0][VALUE_WIDTH-1:0] est_r;
  logic [2:0]                  found_r;

  logic [SCALE_W-1:0] cum_nxt;
  logic [SCALE_W-1:0] total_s;
  idx_t               n_m1;
  value_t             hit_bound;

  // The sum reaches ceil(total * p / 100) exactly when 100 * sum >= total * p,
  // so no division is needed.
  always_comb begin
    total_s   = SCALE_W'(total);
    n_m1      = n - idx_t'(1);
    cum_nxt   = cum_r + times100(SCALE_W'(count));
    hit_bound = (ctrl.idx < n) ? bound_at(bounds, ctrl.idx) : bound_at(bounds, n_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else if (ctrl.start) begin
      if (total == '0 || n == '0) begin
        found_r <= '1;
      end else begin
        found_r <= '0;
      end
    end else if (ctrl.step) begin
      for (int k = 0; k < 3; k++) begin
        if (!found_r[k] && cum_nxt >= tgt_r[k]) begin
          found_r[k] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cum_r    <= '0;
      tgt_r[0] <= times50(total_s);
      tgt_r[1] <= times95(total_s);
      tgt_r[2] <= times99(total_s);
      for (int k = 0; k < 3; k++) begin
        // Without samples or bounds every estimate is zero; otherwise the
        // fallback is the last active bound.
        est_r[k] <= (total == '0 || n == '0) ? '0 : bound_at(bounds, n_m1);
      end
    end else if (ctrl.step) begin
      cum_r <= cum_nxt;
      for (int k = 0; k < 3; k++) begin
        if (!found_r[k] && cum_nxt >= tgt_r[k]) begin
          est_r[k] <= hit_bound;
        end
      end
    end
  end

  assign p50 = est_r[0];
  assign p95 = est_r[1];
  assign p99 = est_r[2];

endmodule

// ===== design/bucket_histogram_percentiles.sv =====
// Bucketed histogram with configurable bounds, percentile estimates and streamed snapshots.
//
// Items arrive on in_valid/in_ready with a command and a sample value. An observe
// item is taken every cycle while idle: its bucket is found on acceptance, the count
// memory is read, and in the next cycle the count is incremented (saturating) and
// written back, with forwarding between back-to-back observes of one bucket. A clear
// item zeroes counts, total and sum. Observe and clear give no result. A query stops
// intake; it scans buckets 0..n through the one memory read port (n = active
// bounds), one bucket a cycle, then reads each bucket again and loads it into the
// output register, each result taking a memory read step and then an output load
// step. The next item is taken once the last result is loaded. A stalled out_ready
// holds the output register and the per-bucket reads and loads wait behind it.
// Reset is synchronous: per-bucket valid bits make all counts read as zero at once,
// so no clearing pass follows reset. The plain cfg_we write port sets the bounds;
// the user must write it only while the block is idle; the block does not enforce it.
module bucket_histogram_percentiles
  import bhp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAIR_W-1:0]    cfg_wdata
);

  // Configuration registers.
  logic [3:0]  bounds_in_use_r;
  bound_regs_t bound_regs_r;
  idx_t        n_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_in_use_r <= '0;
      bound_regs_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_BOUNDS_IN_USE: bounds_in_use_r <= cfg_wdata[3:0];
        REG_PAIR_A:        bound_regs_r[0] <= cfg_wdata;
        REG_PAIR_B:        bound_regs_r[1] <= cfg_wdata;
        REG_PAIR_C:        bound_regs_r[2] <= cfg_wdata;
        REG_PAIR_D:        bound_regs_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n_act = active_bounds(bounds_in_use_r);

  // Input acceptance and bucket lookup.
  logic   in_acc;
  cmd_e   in_cmd;
  value_t sample;
  idx_t   find_idx;

  assign in_acc = in_valid && in_ready;
  assign in_cmd = cmd_e'(in_item.command);
  assign sample = value_t'(in_item.sample_value);

  always_comb begin
    find_idx = '0;
    for (int i = 0; i < MAX_BOUNDS; i++) begin
      if (idx_t'(i) < n_act && bound_at(bound_regs_r, idx_t'(i)) <= sample) begin
        find_idx = find_idx + idx_t'(1);
      end
    end
  end

  // Count memory with per-entry valid bits.
  logic [COUNT_WIDTH-1:0] mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] ent_vld_r;
  count_t                 rd_data_r;
  logic                   rd_vld_r;
  logic                   mem_re;
  idx_t                   mem_raddr;
  logic                   mem_we;
  idx_t                   mem_waddr;
  count_t                 mem_wdata;
  count_t                 rd_cnt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
      rd_vld_r  <= ent_vld_r[mem_raddr];
    end
  end

  assign rd_cnt = rd_vld_r ? rd_data_r : '0;

  // Update stage: the cycle after acceptance.
  logic   s1_vld_r;
  cmd_e   s1_cmd_r;
  idx_t   s1_idx_r;
  value_t s1_val_r;
  logic   s1_obs;
  logic   s1_clr;
  logic   s1_qry;

  logic   fwd_vld_r;
  idx_t   fwd_idx_r;
  count_t fwd_cnt_r;
  logic   clr_prev_r;
  count_t old_cnt;
  count_t new_cnt;

  count_t           total_r;
  logic [SUM_W-1:0] sum_r;

  assign s1_obs = s1_vld_r && s1_cmd_r == CMD_OBSERVE;
  assign s1_clr = s1_vld_r && s1_cmd_r == CMD_CLEAR;
  assign s1_qry = s1_vld_r && s1_cmd_r == CMD_QUERY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc && in_cmd != CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_cmd;
      s1_idx_r <= find_idx;
      s1_val_r <= sample;
    end
  end

  // The memory read of this item may have missed the write of the item just
  // before it, or a clear just before it; those take precedence.
  always_comb begin
    if (clr_prev_r) begin
      old_cnt = '0;
    end else if (fwd_vld_r && fwd_idx_r == s1_idx_r) begin
      old_cnt = fwd_cnt_r;
    end else begin
      old_cnt = rd_cnt;
    end
    new_cnt   = (old_cnt == '1) ? old_cnt : old_cnt + count_t'(1);
    mem_we    = s1_obs;
    mem_waddr = s1_idx_r;
    mem_wdata = new_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r  <= 1'b0;
      clr_prev_r <= 1'b0;
      ent_vld_r  <= '0;
      total_r    <= '0;
      sum_r      <= '0;
    end else begin
      fwd_vld_r  <= s1_obs;
      clr_prev_r <= s1_clr;
      if (s1_clr) begin
        ent_vld_r <= '0;
        total_r   <= '0;
        sum_r     <= '0;
      end else if (s1_obs) begin
        ent_vld_r[s1_idx_r] <= 1'b1;
        total_r <= (total_r == '1) ? total_r : total_r + count_t'(1);
        sum_r   <= sum_r + SUM_W'(s1_val_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_obs) begin
      fwd_idx_r <= s1_idx_r;
      fwd_cnt_r <= new_cnt;
    end
  end

  // Query sequencer.
  state_e     state_r, state_nxt;
  idx_t       scan_idx_r, scan_idx_nxt;
  logic       issued_all_r, issued_all_nxt;
  logic       pend_r, pend_nxt;
  idx_t       pend_idx_r, pend_idx_nxt;
  idx_t       emit_idx_r, emit_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;
  logic       out_load;
  scan_ctrl_t scan_ctrl;
  value_t     p50, p95, p99;

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    issued_all_nxt = issued_all_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    emit_idx_nxt   = emit_idx_r;
    mem_re         = 1'b0;
    mem_raddr      = find_idx;
    out_load       = 1'b0;
    scan_ctrl      = '{start: s1_qry, step: 1'b0, idx: pend_idx_r};

    unique case (state_r)
      ST_IDLE: begin
        mem_re = in_acc && in_cmd == CMD_OBSERVE;
        if (s1_qry) begin
          state_nxt      = ST_SCAN;
          scan_idx_nxt   = '0;
          issued_all_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        mem_raddr      = scan_idx_r;
        scan_ctrl.step = pend_r;
        if (!issued_all_r) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r;
          if (scan_idx_r == n_act) begin
            issued_all_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + idx_t'(1);
          end
        end
        if (pend_r && pend_idx_r == n_act) begin
          state_nxt    = ST_EMIT_RD;
          emit_idx_nxt = '0;
        end
      end
      ST_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = emit_idx_r;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (emit_idx_r == n_act) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + idx_t'(1);
            state_nxt    = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    out_item_nxt.bucket_index    = 4'(emit_idx_r);
    out_item_nxt.bucket_count    = 48'(rd_cnt);
    out_item_nxt.total_count     = 48'(total_r);
    out_item_nxt.value_sum       = sum_r;
    out_item_nxt.median_estimate = 32'(p50);
    out_item_nxt.p95_estimate    = 32'(p95);
    out_item_nxt.p99_estimate    = 32'(p99);
    out_item_nxt.last_bucket     = (emit_idx_r == n_act);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_idx_r   <= '0;
      issued_all_r <= 1'b0;
      pend_r       <= 1'b0;
      pend_idx_r   <= '0;
      emit_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      issued_all_r <= issued_all_nxt;
      pend_r       <= pend_nxt;
      pend_idx_r   <= pend_idx_nxt;
      emit_idx_r   <= emit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  bhp_pct_scan u_pct_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (scan_ctrl),
    .count  (rd_cnt),
    .total  (total_r),
    .n      (n_act),
    .bounds (bound_regs_r),
    .p50    (p50),
    .p95    (p95),
    .p99    (p99)
  );

  assign in_ready  = (state_r == ST_IDLE) && !s1_qry;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_qry |=> state_r == ST_SCAN)
    else $error("query in update stage did not start the bucket scan");

  a_load_only_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT_LD)
    else $error("output became valid outside the emit load step");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mem_we)
    else $error("count memory written while a query is in progress");
`endif

endmodule

// ===== tb/bucket_histogram_percentiles_tb.sv =====
// Self-checking testbench for the bucket histogram with streamed percentile snapshots.
module bucket_histogram_percentiles_tb;
  import bhp_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned PHASE_ITEMS  = 35;

  // Tracks the histogram state and the snapshot results that queries should stream out.
  class hist_predictor;
    logic [3:0]       bounds_reg;
    logic [63:0]      pair_regs[NUM_PAIRS];
    logic [47:0]      counts[NUM_BUCKETS];
    logic [47:0]      total;
    logic [63:0]      sum;
    out_item_t        pending[$];
    int unsigned      errors;

    function new();
      bounds_reg = '0;
      foreach (pair_regs[k]) pair_regs[k] = '0;
      foreach (counts[k]) counts[k] = '0;
      total  = '0;
      sum    = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] data);
      case (idx)
        REG_BOUNDS_IN_USE: bounds_reg = data[3:0];
        REG_PAIR_A:        pair_regs[0] = data;
        REG_PAIR_B:        pair_regs[1] = data;
        REG_PAIR_C:        pair_regs[2] = data;
        REG_PAIR_D:        pair_regs[3] = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] bound_value(int unsigned i);
      logic [63:0] pair;
      pair = pair_regs[i / 2];
      return (i % 2) ? pair[63:32] : pair[31:0];
    endfunction

    function logic [31:0] estimate(int unsigned n, logic [63:0] pct);
      logic [63:0] target;
      logic [63:0] cum;
      if (total == 0 || n == 0) return '0;
      target = (64'(total) / 100) * pct + ((64'(total) % 100) * pct + 99) / 100;
      if (target == 0) target = 1;
      // Nine 48-bit counts cannot overflow a 64-bit running sum.
      cum = '0;
      for (int i = 0; i <= n; i++) begin
        cum = cum + 64'(counts[i]);
        if (cum >= target) return (i < n) ? bound_value(i) : bound_value(n - 1);
      end
      return bound_value(n - 1);
    endfunction

    // Applies one accepted item and returns how many results it will produce.
    function int note_item(in_item_t it);
      int unsigned n;
      int unsigned slot;
      out_item_t   r;
      logic [31:0] p50, p95, p99;
      n = (bounds_reg > MAX_BOUNDS) ? MAX_BOUNDS : bounds_reg;
      case (it.command)
        CMD_OBSERVE: begin
          slot = 0;
          for (int i = 0; i < n; i++)
            if (bound_value(i) <= it.sample_value) slot++;
          if (counts[slot] != '1) counts[slot] = counts[slot] + 1'b1;
          if (total != '1) total = total + 1'b1;
          sum = sum + 64'(it.sample_value);
          return 0;
        end
        CMD_QUERY: begin
          p50 = estimate(n, 50);
          p95 = estimate(n, 95);
          p99 = estimate(n, 99);
          for (int i = 0; i <= n; i++) begin
            r.bucket_index    = 4'(i);
            r.bucket_count    = counts[i];
            r.total_count     = total;
            r.value_sum       = sum;
            r.median_estimate = p50;
            r.p95_estimate    = p95;
            r.p99_estimate    = p99;
            r.last_bucket     = (i == n);
            pending.insert(pending.size(), r);
          end
          return n + 1;
        end
        CMD_CLEAR: begin
          foreach (counts[k]) counts[k] = '0;
          total = '0;
          sum   = '0;
          return 0;
        end
        default: return 0;
      endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("bucket_index: expected no item, actual %0h", got.bucket_index);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("bucket_index", 64'(want.bucket_index), 64'(got.bucket_index));
      compare("bucket_count", 64'(want.bucket_count), 64'(got.bucket_count));
      compare("total_count", 64'(want.total_count), 64'(got.total_count));
      compare("value_sum", want.value_sum, got.value_sum);
      compare("median_estimate", 64'(want.median_estimate), 64'(got.median_estimate));
      compare("p95_estimate", 64'(want.p95_estimate), 64'(got.p95_estimate));
      compare("p99_estimate", 64'(want.p99_estimate), 64'(got.p99_estimate));
      compare("last_bucket", 64'(want.last_bucket), 64'(got.last_bucket));
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAIR_W-1:0]    cfg_wdata = '0;

  hist_predictor pred = new();

  logic [31:0]  cur_bounds[8];
  bit           in_gaps    = 1'b1;
  bit           out_gaps   = 1'b1;
  bit           hold_req   = 1'b0;
  int unsigned  quiet_cycles = 0;
  int unsigned  random_items = 0;

  bucket_histogram_percentiles uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) pred.check_result(out_item);
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (out_gaps) begin
        out_ready <= ($urandom_range(99) >= 35);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves in_valid high after acceptance so back-to-back items need no extra edge.
  task automatic offer_item(input cmd_e cmd, input logic [31:0] value);
    in_item_t it;
    it.command      = cmd;
    it.sample_value = value;
    if (in_gaps) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(pred.note_item(it));
  endtask

  task automatic send(input cmd_e cmd, input logic [31:0] value);
    offer_item(cmd, value);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pred.pending.size() != 0) @(posedge clk);
    // Observes and clears produce nothing, so give their write-back time to land.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    pred.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_bounds(input logic [3:0] n);
    write_reg(REG_BOUNDS_IN_USE, 64'(n));
    write_reg(REG_PAIR_A, {cur_bounds[1], cur_bounds[0]});
    write_reg(REG_PAIR_B, {cur_bounds[3], cur_bounds[2]});
    write_reg(REG_PAIR_C, {cur_bounds[5], cur_bounds[4]});
    write_reg(REG_PAIR_D, {cur_bounds[7], cur_bounds[6]});
    cfg_we <= 1'b0;
  endtask

  task automatic fill_bounds(input bit sorted);
    logic [32:0] acc;
    int unsigned span;
    span = 1 << (2 * $urandom_range(1, 14));
    acc  = (span > (1 << 20)) ? 33'($urandom) : 33'($urandom_range(0, 64));
    for (int i = 0; i < 8; i++) begin
      if (!sorted) begin
        cur_bounds[i] = $urandom;
      end else begin
        if (i > 0) acc = acc + 33'($urandom_range(0, span));
        cur_bounds[i] = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      end
    end
  endtask

  // Half the values are right at a bound or one off it, so bucket edges get exercised.
  function automatic logic [31:0] pick_sample();
    int unsigned r;
    logic [31:0] b;
    r = $urandom_range(99);
    b = cur_bounds[$urandom_range(7)];
    if (r < 50) return b + 32'($urandom_range(2)) - 32'd1;
    if (r < 75) return $urandom;
    if (r < 90) return 32'($urandom_range(15));
    return 32'hFFFF_FFF0 | 32'($urandom_range(15));
  endfunction

  initial begin
    int unsigned phase;
    int unsigned r;
    logic [3:0]  n;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No bounds after reset: one bucket and all estimates zero.
    send(CMD_QUERY, 32'd0);
    send(CMD_OBSERVE, 32'd0);
    send(CMD_OBSERVE, 32'hFFFF_FFFF);
    send(CMD_NONE, 32'hFFFF_FFFF);
    send(CMD_QUERY, 32'hFFFF_FFFF);
    drain_results();

    // Full set of sorted bounds; counts from the single-bucket phase are kept.
    cur_bounds = '{32'd0, 32'd10, 32'd100, 32'd1000, 32'd100000, 32'd10000000,
                   32'h8000_0000, 32'hFFFF_FFFF};
    program_bounds(4'd8);
    send(CMD_QUERY, 32'd0);
    send(CMD_CLEAR, 32'd0);
    send(CMD_QUERY, 32'd0);
    send(CMD_OBSERVE, 32'd0);
    send(CMD_OBSERVE, 32'd9);
    send(CMD_OBSERVE, 32'd10);
    send(CMD_OBSERVE, 32'd99);
    send(CMD_OBSERVE, 32'hFFFF_FFFF);
    send(CMD_OBSERVE, 32'h7FFF_FFFF);
    send(CMD_OBSERVE, 32'd12345);
    send(CMD_QUERY, 32'd0);
    drain_results();

    // Count above the maximum, bounds out of order.
    cur_bounds = '{32'd500, 32'd20, 32'hFFFF_FFFF, 32'd20, 32'd0, 32'd7000, 32'd3,
                   32'd100};
    program_bounds(4'd15);
    send(CMD_OBSERVE, 32'd20);
    send(CMD_OBSERVE, 32'd2);
    send(CMD_OBSERVE, 32'd6999);
    send(CMD_QUERY, 32'd0);
    drain_results();

    // Fewer bounds without a clear: upper buckets drop out of the report.
    program_bounds(4'd3);
    send(CMD_OBSERVE, 32'd50);
    send(CMD_QUERY, 32'd0);
    drain_results();

    phase = 0;
    while (random_items < 240) begin
      case (phase)
        0:       n = 4'd8;
        1:       n = 4'd0;
        2:       n = 4'd15;
        3:       n = 4'd8;
        default: n = 4'($urandom_range(15));
      endcase
      fill_bounds(phase % 4 != 2);
      program_bounds(n);
      in_gaps  = (phase != 3);
      out_gaps = (phase != 3);
      if (phase == 5) begin
        // Long receiver hold-off behind a query while observes wait to be taken.
        hold_req = 1'b1;
        offer_item(CMD_QUERY, $urandom);
        random_items++;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 82) offer_item(CMD_OBSERVE, pick_sample());
        else if (r < 90) offer_item(CMD_QUERY, $urandom);
        else if (r < 95) offer_item(CMD_CLEAR, $urandom);
        else offer_item(CMD_NONE, $urandom);
        random_items++;
      end
      send(CMD_QUERY, $urandom);
      drain_results();
      phase++;
    end

    in_valid <= 1'b0;
    while (pred.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pred.errors == 0 && pred.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
